// ===== design/tlfk_pkg.sv =====
// Package for the two-link arm forward kinematics block.
// Field widths, register codes and the elaboration-time sine table builder.
// No dependencies.
package tlfk_pkg;

	localparam int ANGLE_W         = 9;
	localparam int LEN_W           = 10;
	localparam int COORD_W         = 11;
	localparam int OUT_W           = 20;
	localparam int OUT_FRAC        = 8;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 11;
	localparam int TRIG_FRAC_BITS_DEF = 14;
	localparam int SIN_ENTRY_W     = 21;   // holds 2**frac for the widest table
	localparam int SIN_IDX_W       = 7;    // 0..90 degrees

	localparam logic [ANGLE_W-1:0] DEG_90   = ANGLE_W'(90);
	localparam logic [ANGLE_W-1:0] DEG_180  = ANGLE_W'(180);
	localparam logic [ANGLE_W-1:0] DEG_270  = ANGLE_W'(270);
	localparam logic [ANGLE_W-1:0] DEG_FULL = ANGLE_W'(360);

	localparam logic [LEN_W-1:0]   UPPER_LEN_RST = LEN_W'(200);
	localparam logic [LEN_W-1:0]   LOWER_LEN_RST = LEN_W'(200);

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UPPER_LEN,
		REG_LOWER_LEN,
		REG_BASE_X,
		REG_BASE_Y
	} cfg_reg_t;

	typedef logic [SIN_ENTRY_W-1:0] sin_tab_t [0:90];

	// First-quadrant sine per degree: Q30 Taylor series through x^17,
	// each term truncated, then rounded half-up to frac fraction bits.
	function automatic sin_tab_t build_sin_tab(input int unsigned frac);
		sin_tab_t            tab;
		logic [63:0]         x;
		logic [63:0]         x2;
		logic [63:0]         term;
		logic [63:0]         rnd;
		logic signed [63:0]  sum;
		for (int d = 0; d <= 90; d++) begin
			x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
			x2   = (x * x) >> 30;
			term = x;
			sum  = $signed(x);
			term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
			if (sum < 0)
				sum = '0;
			rnd    = ($unsigned(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
			tab[d] = SIN_ENTRY_W'(rnd);
		end
		return tab;
	endfunction

endpackage

// ===== design/tlfk_if.sv =====
// Channel interfaces of the arm kinematics block: joint commands in,
// positions out. Depends on tlfk_pkg.
interface tlfk_cmd_if
	import tlfk_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               joint_select;
	logic [ANGLE_W-1:0] angle_deg;

	modport source (output valid, output joint_select, output angle_deg, input ready);
	modport sink   (input valid, input joint_select, input angle_deg, output ready);
endinterface

interface tlfk_pos_if
	import tlfk_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] elbow_x;
	logic signed [OUT_W-1:0] elbow_y;
	logic signed [OUT_W-1:0] hand_x;
	logic signed [OUT_W-1:0] hand_y;

	modport source (output valid, output elbow_x, output elbow_y,
		output hand_x, output hand_y, input ready);
	modport sink   (input valid, input elbow_x, input elbow_y,
		input hand_x, input hand_y, output ready);
endinterface

// ===== design/tlfk_trig.sv =====
// Sine and cosine of a whole-degree angle from the first-quadrant table.
// Depends on tlfk_pkg.
module tlfk_trig
	import tlfk_pkg::*;
#(
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
	input  logic [ANGLE_W-1:0]              angle,
	output logic signed [TRIG_FRAC_BITS+1:0] sin_v,
	output logic signed [TRIG_FRAC_BITS+1:0] cos_v
);

	localparam sin_tab_t SIN_TAB = build_sin_tab(TRIG_FRAC_BITS);

	typedef struct packed {
		logic                 neg;
		logic [SIN_IDX_W-1:0] idx;
	} quad_t;

	// fold 0..359 onto the first quadrant
	function automatic quad_t fold(input logic [ANGLE_W-1:0] d);
		quad_t q;
		priority if (d <= DEG_90) begin
			q.neg = 1'b0; q.idx = SIN_IDX_W'(d);
		end else if (d <= DEG_180) begin
			q.neg = 1'b0; q.idx = SIN_IDX_W'(DEG_180 - d);
		end else if (d <= DEG_270) begin
			q.neg = 1'b1; q.idx = SIN_IDX_W'(d - DEG_180);
		end else begin
			q.neg = 1'b1; q.idx = SIN_IDX_W'(DEG_FULL - d);
		end
		return q;
	endfunction

	function automatic logic signed [TRIG_FRAC_BITS+1:0] lookup(input quad_t q);
		logic signed [TRIG_FRAC_BITS+1:0] mag;
		mag = $signed({1'b0, SIN_TAB[q.idx][TRIG_FRAC_BITS:0]});
		return q.neg ? -mag : mag;
	endfunction

	logic [ANGLE_W-1:0] cos_ang;

	always_comb begin
		cos_ang = angle + DEG_90;
		if (cos_ang >= DEG_FULL)
			cos_ang = cos_ang - DEG_FULL;
	end

	assign sin_v = lookup(fold(angle));
	assign cos_v = lookup(fold(cos_ang));

endmodule

// ===== design/two_link_forward_kinematics.sv =====
// Top level of the two-link planar arm forward kinematics block.
// Depends on tlfk_pkg, tlfk_if (tlfk_cmd_if, tlfk_pos_if) and tlfk_trig.
//
// Usage:
//   cmd beats set one joint angle (joint_select 0 shoulder, 1 elbow) in whole
//   degrees; 360..511 is folded by one turn. Each beat yields one pos beat with
//   elbow and hand positions, signed Q11.8, rounded and saturated.
//   Link lengths and base position come through the cfg write port (cfg_en,
//   cfg_addr, cfg_data); write them only while no beat is in flight.
//   An accepted cmd beat is registered in the angle stage, then its result in
//   the output register. Throughput: one beat per cycle while pos is ready;
//   the angle register stage and the output register form a two-deep pipeline,
//   with the table lookups, one multiply per coordinate and round/saturate between.
//   Stall: while pos is held, the output register keeps its beat and one more
//   beat can wait in the angle stage; cmd.ready drops only when both are full.
//   Reset: angles go to 0, links to 200, base to the origin, pipeline empty.
module two_link_forward_kinematics
	import tlfk_pkg::*;
#(
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tlfk_cmd_if.sink              cmd,
	tlfk_pos_if.source            pos
);

	localparam int TRIG_W = TRIG_FRAC_BITS + 2;
	localparam int POS_W  = TRIG_FRAC_BITS + 13;
	localparam int SH     = TRIG_FRAC_BITS - OUT_FRAC;
	localparam logic signed [POS_W:0] HALF  = (POS_W+1)'((64'sd1 <<< SH) >>> 1);
	localparam logic signed [POS_W:0] R_MAX = (POS_W+1)'((64'sd1 <<< (OUT_W-1)) - 64'sd1);
	localparam logic signed [POS_W:0] R_MIN = (POS_W+1)'(-(64'sd1 <<< (OUT_W-1)));

	// configuration
	logic [LEN_W-1:0]          upper_len_q;
	logic [LEN_W-1:0]          lower_len_q;
	logic signed [COORD_W-1:0] base_x_q;
	logic signed [COORD_W-1:0] base_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_len_q <= UPPER_LEN_RST;
			lower_len_q <= LOWER_LEN_RST;
			base_x_q    <= '0;
			base_y_q    <= '0;
		end else if (cfg_en) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_UPPER_LEN: upper_len_q <= cfg_data[LEN_W-1:0];
				REG_LOWER_LEN: lower_len_q <= cfg_data[LEN_W-1:0];
				REG_BASE_X:    base_x_q    <= $signed(cfg_data[COORD_W-1:0]);
				REG_BASE_Y:    base_y_q    <= $signed(cfg_data[COORD_W-1:0]);
			endcase
		end
	end

	// handshake
	logic valid_s1;
	logic out_valid_q;
	logic advance;
	logic accept;

	assign advance   = !out_valid_q || pos.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign accept    = cmd.valid && cmd.ready;

	// joint angles, updated as a beat enters the first stage
	logic [ANGLE_W-1:0] shoulder_s1;
	logic [ANGLE_W-1:0] elbow_s1;
	logic [ANGLE_W-1:0] angle_in;

	assign angle_in = (cmd.angle_deg >= DEG_FULL) ? cmd.angle_deg - DEG_FULL : cmd.angle_deg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			shoulder_s1 <= '0;
			elbow_s1    <= '0;
		end else begin
			if (cmd.ready)
				valid_s1 <= cmd.valid;
			if (accept) begin
				if (cmd.joint_select)
					elbow_s1 <= angle_in;
				else
					shoulder_s1 <= angle_in;
			end
		end
	end

	// t = (180 - s + e) mod 360
	logic signed [ANGLE_W+1:0] t_raw;
	logic [ANGLE_W-1:0]        t_ang;

	always_comb begin
		t_raw = $signed({2'b00, elbow_s1}) - $signed({2'b00, shoulder_s1})
			+ $signed({2'b00, DEG_180});
		if (t_raw < 0)
			t_raw = t_raw + $signed({2'b00, DEG_FULL});
		else if (t_raw >= $signed({2'b00, DEG_FULL}))
			t_raw = t_raw - $signed({2'b00, DEG_FULL});
		t_ang = ANGLE_W'(t_raw);
	end

	logic signed [TRIG_W-1:0] sin_s;
	logic signed [TRIG_W-1:0] cos_s;
	logic signed [TRIG_W-1:0] sin_t;
	logic signed [TRIG_W-1:0] cos_t;

	tlfk_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_shoulder (
		.angle (shoulder_s1),
		.sin_v (sin_s),
		.cos_v (cos_s)
	);

	tlfk_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_hand (
		.angle (t_ang),
		.sin_v (sin_t),
		.cos_v (cos_t)
	);

	// positions with TRIG_FRAC_BITS fraction bits
	logic signed [POS_W-1:0] l1_w;
	logic signed [POS_W-1:0] l2_w;
	logic signed [POS_W-1:0] ex;
	logic signed [POS_W-1:0] ey;
	logic signed [POS_W-1:0] hx;
	logic signed [POS_W-1:0] hy;

	assign l1_w = POS_W'($signed({1'b0, upper_len_q}));
	assign l2_w = POS_W'($signed({1'b0, lower_len_q}));
	assign ex = (POS_W'(base_x_q) <<< TRIG_FRAC_BITS) - l1_w * POS_W'(cos_s);
	assign ey = (POS_W'(base_y_q) <<< TRIG_FRAC_BITS) + l1_w * POS_W'(sin_s);
	assign hx = ex - l2_w * POS_W'(cos_t);
	assign hy = ey + l2_w * POS_W'(sin_t);

	// round to nearest, ties up, then clamp to Q11.8
	function automatic logic signed [OUT_W-1:0] to_q8(input logic signed [POS_W-1:0] v);
		logic signed [POS_W:0] r;
		r = ((POS_W+1)'(v) + HALF) >>> SH;
		if (r > R_MAX)
			r = R_MAX;
		else if (r < R_MIN)
			r = R_MIN;
		return OUT_W'(r);
	endfunction

	logic signed [OUT_W-1:0] elbow_x_q;
	logic signed [OUT_W-1:0] elbow_y_q;
	logic signed [OUT_W-1:0] hand_x_q;
	logic signed [OUT_W-1:0] hand_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			elbow_x_q <= to_q8(ex);
			elbow_y_q <= to_q8(ey);
			hand_x_q  <= to_q8(hx);
			hand_y_q  <= to_q8(hy);
		end
	end

	assign pos.valid   = out_valid_q;
	assign pos.elbow_x = elbow_x_q;
	assign pos.elbow_y = elbow_y_q;
	assign pos.hand_x  = hand_x_q;
	assign pos.hand_y  = hand_y_q;

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat did not reach the angle stage");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(shoulder_s1) && $stable(elbow_s1))
		else $error("angle stage changed while stalled");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		shoulder_s1 < DEG_FULL && elbow_s1 < DEG_FULL)
		else $error("joint angle beyond one turn");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a beat in the angle stage");

endmodule

// ===== tb/tb_two_link_forward_kinematics.sv =====
// Testbench for two_link_forward_kinematics: joint beats in, elbow/hand positions out,
// checked against a local fixed-point arm model with its own sine table.
// Depends on tlfk_pkg, tlfk_if and the block itself.
`timescale 1ns / 100ps

module tb_two_link_forward_kinematics;
	import tlfk_pkg::*;

	localparam int     FRAC    = TRIG_FRAC_BITS_DEF;
	localparam longint UNIT    = longint'(1) << FRAC;
	localparam longint POS_MAX = (longint'(1) << (OUT_W - 1)) - 1;
	localparam longint POS_MIN = -(longint'(1) << (OUT_W - 1));
	localparam int     PHASES  = 6;
	localparam int     PHASE_BEATS = 190;

	typedef struct packed {
		logic signed [OUT_W-1:0] ex;
		logic signed [OUT_W-1:0] ey;
		logic signed [OUT_W-1:0] hx;
		logic signed [OUT_W-1:0] hy;
	} arm_pos_t;

	typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		cfg_reg_t  reg_sel;
		int        value;
		bit        joint;
		int        angle;
		bit        typed;
		arm_pos_t  want;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_en;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;

	tlfk_cmd_if cmd ();
	tlfk_pos_if pos ();

	two_link_forward_kinematics dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_en   (cfg_en),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.pos      (pos)
	);

	// arm state and settings as the block should hold them
	int unsigned shoulder_deg;
	int unsigned elbow_deg;
	int          upper_len;
	int          lower_len;
	int          base_x;
	int          base_y;
	longint      quad_sine [0:90];

	arm_pos_t pose_queue [$];
	arm_pos_t want_pose;
	arm_pos_t got_pose;
	int       fail_count;
	int       stall_left;
	bit       tx_idle_on;
	bit       rx_idle_on;

	// directed part: extremes, every joint, folded angles, saturation both ways
	row_t plan [35] = '{
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 0,   1'b1, '{-51200, 0, 0, 0}},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b1, 0,   1'b1, '{-51200, 0, 0, 0}},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 90,  1'b1, '{0, 51200, 0, 102400}},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b1, 359, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 360, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 511, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b1, 256, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 45,  1'b0, '0},
		'{ROW_CFG, REG_UPPER_LEN, 1023,  1'b0, 0, 1'b0, '0},
		'{ROW_CFG, REG_LOWER_LEN, 1023,  1'b0, 0, 1'b0, '0},
		'{ROW_CFG, REG_BASE_X,    1023,  1'b0, 0, 1'b0, '0},
		'{ROW_CFG, REG_BASE_Y,    -1024, 1'b0, 0, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 180, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b1, 180, 1'b1, '{523776, -262144, 524287, -262144}},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 270, 1'b1, '{261888, -524032, 261888, -262144}},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b1, 0,   1'b1, '{261888, -524032, 261888, -524288}},
		'{ROW_CFG, REG_UPPER_LEN, 0,     1'b0, 0, 1'b0, '0},
		'{ROW_CFG, REG_LOWER_LEN, 0,     1'b0, 0, 1'b0, '0},
		'{ROW_CFG, REG_BASE_X,    -1024, 1'b0, 0, 1'b0, '0},
		'{ROW_CFG, REG_BASE_Y,    1023,  1'b0, 0, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 123, 1'b1, '{-262144, 261888, -262144, 261888}},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b1, 511, 1'b1, '{-262144, 261888, -262144, 261888}},
		'{ROW_CFG, REG_UPPER_LEN, 1,     1'b0, 0, 1'b0, '0},
		'{ROW_CFG, REG_LOWER_LEN, 1023,  1'b0, 0, 1'b0, '0},
		'{ROW_CFG, REG_BASE_X,    0,     1'b0, 0, 1'b0, '0},
		'{ROW_CFG, REG_BASE_Y,    0,     1'b0, 0, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 1,   1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b1, 300, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 89,  1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b1, 91,  1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 179, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 181, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b1, 269, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b0, 271, 1'b0, '0},
		'{ROW_CMD, REG_UPPER_LEN, 0, 1'b1, 384, 1'b0, '0}
	};

	always #4 clk = ~clk;

	// Q30 series for sin(x), odd terms through x^17, each term truncated
	function automatic longint quadrant_sine(int unsigned d);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] acc;
		x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
		x2   = (x * x) >> 30;
		term = x;
		acc  = $signed(x);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2)
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		if (acc < 0)
			acc = 0;
		return longint'((acc + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC));
	endfunction

	function automatic longint sine_of(int unsigned d);
		d = d % 360;
		if (d <= 90)
			return quad_sine[d];
		if (d <= 180)
			return quad_sine[180 - d];
		if (d <= 270)
			return -quad_sine[d - 180];
		return -quad_sine[360 - d];
	endfunction

	function automatic longint cosine_of(int unsigned d);
		return sine_of(d % 360 + 90);
	endfunction

	// nearest, ties upward, then clamp to the output range
	function automatic logic signed [OUT_W-1:0] to_q8(longint v);
		longint r;
		r = (v + (longint'(1) << (FRAC - OUT_FRAC - 1))) >>> (FRAC - OUT_FRAC);
		if (r > POS_MAX)
			r = POS_MAX;
		if (r < POS_MIN)
			r = POS_MIN;
		return OUT_W'(r);
	endfunction

	function automatic arm_pos_t next_pose(bit joint, logic [ANGLE_W-1:0] angle);
		int unsigned a;
		int unsigned turn;
		longint      ex;
		longint      ey;
		longint      hx;
		longint      hy;
		arm_pos_t    p;
		a = angle;
		if (a >= 360)
			a = a - 360;
		if (joint)
			elbow_deg = a;
		else
			shoulder_deg = a;
		ex   = longint'(base_x) * UNIT - longint'(upper_len) * cosine_of(shoulder_deg);
		ey   = longint'(base_y) * UNIT + longint'(upper_len) * sine_of(shoulder_deg);
		turn = (540 - shoulder_deg + elbow_deg) % 360;
		hx   = ex - longint'(lower_len) * cosine_of(turn);
		hy   = ey + longint'(lower_len) * sine_of(turn);
		p.ex = to_q8(ex);
		p.ey = to_q8(ey);
		p.hx = to_q8(hx);
		p.hy = to_q8(hy);
		return p;
	endfunction

	task automatic write_reg(cfg_reg_t sel, int value);
		logic signed [COORD_W-1:0] coord;
		coord    = COORD_W'(value);
		cfg_en   <= 1'b1;
		cfg_addr <= sel;
		cfg_data <= CFG_DATA_W'(value);
		case (sel)
			REG_UPPER_LEN: upper_len = value & 1023;
			REG_LOWER_LEN: lower_len = value & 1023;
			REG_BASE_X:    base_x    = coord;
			REG_BASE_Y:    base_y    = coord;
		endcase
		@(posedge clk);
	endtask

	// sender holds off until every pending position beat has come back
	task automatic wait_for_positions();
		cmd.valid <= 1'b0;
		cfg_en    <= 1'b0;
		@(posedge clk);
		while (pose_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// leaves valid high on return so back-to-back beats need no toggle
	task automatic send_joint(bit joint, int angle, bit typed, arm_pos_t want);
		arm_pos_t p;
		cfg_en           <= 1'b0;
		cmd.valid        <= 1'b1;
		cmd.joint_select <= joint;
		cmd.angle_deg    <= ANGLE_W'(angle);
		do
			@(posedge clk);
		while (cmd.ready !== 1'b1);
		p = next_pose(joint, ANGLE_W'(angle));
		pose_queue.push_back(typed ? want : p);
	endtask

	task automatic flag_fault(string what, arm_pos_t want, arm_pos_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t %s: expected ex %0d ey %0d hx %0d hy %0d, got ex %0d ey %0d hx %0d hy %0d",
				$realtime, what, want.ex, want.ey, want.hx, want.hy,
				got.ex, got.ey, got.hx, got.hy);
	endtask

	// receiver: random stall bursts, and the check of each position beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (pos.valid === 1'b1 && pos.ready === 1'b1) begin
				got_pose = '{pos.elbow_x, pos.elbow_y, pos.hand_x, pos.hand_y};
				if (pose_queue.size() == 0) begin
					flag_fault("unexpected position beat", '0, got_pose);
				end else begin
					want_pose = pose_queue.pop_front();
					if (got_pose !== want_pose)
						flag_fault("position mismatch", want_pose, got_pose);
				end
			end
			if (stall_left > 0) begin
				pos.ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				pos.ready  <= 1'b0;
				stall_left <= $urandom_range(0, 3);
			end else begin
				pos.ready <= 1'b1;
			end
		end
	end

	initial begin
		bit       last;
		bit       joint;
		int       angle;
		int       v;
		int       hold_at;
		cfg_reg_t sel;
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_en           = 1'b0;
		cfg_addr         = REG_UPPER_LEN;
		cfg_data         = '0;
		cmd.valid        = 1'b0;
		cmd.joint_select = 1'b0;
		cmd.angle_deg    = '0;
		pos.ready        = 1'b0;
		fail_count       = 0;
		stall_left       = 0;
		tx_idle_on       = 1'b0;
		rx_idle_on       = 1'b0;
		for (int d = 0; d <= 90; d++)
			quad_sine[d] = quadrant_sine(d);
		shoulder_deg = 0;
		elbow_deg    = 0;
		upper_len    = 200;
		lower_len    = 200;
		base_x       = 0;
		base_y       = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_for_positions();
				write_reg(plan[i].reg_sel, plan[i].value);
			end else begin
				send_joint(plan[i].joint, plan[i].angle, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			last = (ph == PHASES - 1);
			wait_for_positions();
			for (int r = 0; r < 4; r++) begin
				sel = cfg_reg_t'(r);
				if (sel == REG_UPPER_LEN || sel == REG_LOWER_LEN) begin
					case ($urandom_range(0, 3))
						0:       v = 0;
						1:       v = 1023;
						default: v = $urandom_range(0, 1023);
					endcase
				end else begin
					case ($urandom_range(0, 3))
						0:       v = -1024;
						1:       v = 1023;
						default: v = int'($urandom_range(0, 2047)) - 1024;
					endcase
				end
				write_reg(sel, v);
			end
			hold_at = $urandom_range(20, PHASE_BEATS - 20);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				// idling switches on and off in stretches, never in the closing phase
				if (n % 40 == 0) begin
					tx_idle_on = !last && $urandom_range(0, 2) != 0;
					rx_idle_on = !last && $urandom_range(0, 2) != 0;
				end
				if (n == hold_at) begin
					wait_for_positions();
				end else if (tx_idle_on && $urandom_range(0, 3) == 0) begin
					cmd.valid <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
				joint = $urandom_range(0, 1);
				case ($urandom_range(0, 15))
					0:       angle = $urandom_range(360, 511);
					1:       angle = 90 * $urandom_range(0, 3);
					2:       angle = 359;
					default: angle = $urandom_range(0, 359);
				endcase
				send_joint(joint, angle, 1'b0, '0);
			end
		end

		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pose_queue.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
